@@ rtl/ipps_pkg.sv @@
// Shared types and constants for the IPv4 prefix packet steering block.
package ipps_pkg;

  // Frame layout
  localparam logic [5:0] EthTypeHiOffset = 6'd12;
  localparam logic [5:0] EthTypeLoOffset = 6'd13;
  localparam logic [5:0] SrcStartPlain   = 6'd26;  // 14 byte header + 12
  localparam logic [5:0] SrcStartVlan    = 6'd30;  // plus 4 byte tag
  localparam logic [5:0] OffsetMax       = 6'd63;
  localparam logic [15:0] VlanTpid       = 16'h8100;

  // Prefix handling
  localparam int unsigned BinBits       = 8;
  localparam logic [4:0]  MaxPrefixLen  = 5'd24;

  // Configuration port
  localparam int unsigned CfgDataWidth = 32;

  typedef enum logic [0:0] {
    REG_PREFIX_ADDRESS = 1'b0,
    REG_PREFIX_LENGTH  = 1'b1
  } cfg_reg_t;

  // Captured addresses of one finished frame
  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic        too_short;
  } frame_rec_t;

  // Front to queue push
  typedef struct packed {
    logic       push;
    frame_rec_t rec;
  } front_push_t;

endpackage

@@ rtl/ipps_front.sv @@
// Byte parser: tracks offset, ethertype and VLAN tag, captures both addresses.
module ipps_front import ipps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  frame_byte,
  input  logic        last_byte,
  output front_push_t push_out
);

  logic [5:0]  byte_offset;
  logic [7:0]  ethertype_upper;
  logic        vlan_tagged;
  logic [31:0] source_address;
  logic [31:0] destination_address;

  logic [5:0]  byte_offset_next;
  logic [7:0]  ethertype_upper_next;
  logic        vlan_tagged_next;
  logic [31:0] source_address_next;
  logic [31:0] destination_address_next;
  logic [5:0]  src_start;

  // Decode the current byte's role and build next state
  always_comb begin
    src_start = vlan_tagged ? SrcStartVlan : SrcStartPlain;
    ethertype_upper_next     = ethertype_upper;
    vlan_tagged_next         = vlan_tagged;
    source_address_next      = source_address;
    destination_address_next = destination_address;
    if (byte_offset == EthTypeHiOffset) begin
      ethertype_upper_next = frame_byte;
    end else if (byte_offset == EthTypeLoOffset) begin
      vlan_tagged_next = ({ethertype_upper, frame_byte} == VlanTpid);
    end else if (byte_offset >= src_start && byte_offset < src_start + 6'd4) begin
      source_address_next = {source_address[23:0], frame_byte};
    end else if (byte_offset >= src_start + 6'd4 && byte_offset < src_start + 6'd8) begin
      destination_address_next = {destination_address[23:0], frame_byte};
    end
    byte_offset_next = (byte_offset < OffsetMax) ? byte_offset + 6'd1 : byte_offset;
  end

  // Hand the finished frame to the queue on its last beat
  always_comb begin
    push_out.push                    = accept && last_byte;
    push_out.rec.source_address      = source_address_next;
    push_out.rec.destination_address = destination_address_next;
    push_out.rec.too_short           = (byte_offset < src_start + 6'd7);
  end

  // Advance on every accepted beat, clear at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset         <= '0;
      ethertype_upper     <= '0;
      vlan_tagged         <= 1'b0;
      source_address      <= '0;
      destination_address <= '0;
    end else if (accept) begin
      if (last_byte) begin
        byte_offset         <= '0;
        ethertype_upper     <= '0;
        vlan_tagged         <= 1'b0;
        source_address      <= '0;
        destination_address <= '0;
      end else begin
        byte_offset         <= byte_offset_next;
        ethertype_upper     <= ethertype_upper_next;
        vlan_tagged         <= vlan_tagged_next;
        source_address      <= source_address_next;
        destination_address <= destination_address_next;
      end
    end
  end

endmodule

@@ rtl/ipps_queue.sv @@
// Two-entry queue of finished frame records between parser and matcher.
module ipps_queue import ipps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  front_push_t push_in,
  input  logic        pop,
  output logic        full,
  output logic        head_valid,
  output frame_rec_t  head
);

  frame_rec_t  entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];
  assign do_push    = push_in.push && !full;
  assign do_pop     = pop && head_valid;

  // Store pushed records
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_in.rec;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/ipps_back.sv @@
// Prefix matcher: masks both addresses, picks the bin, holds the result beat.
module ipps_back import ipps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] prefix_address,
  input  logic [4:0]  prefix_length,
  input  logic        head_valid,
  input  frame_rec_t  head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        matched,
  output logic        used_destination,
  output logic [7:0]  bin,
  output logic        too_short
);

  logic [4:0]         len;
  logic [31:0]        mask;
  logic [31:0]        net;
  logic [4:0]         shr;
  logic               src_hit;
  logic               dst_hit;
  logic               matched_next;
  logic               used_destination_next;
  logic [BinBits-1:0] bin_next;

  // Build mask and compare both addresses against the prefix
  always_comb begin
    len     = (prefix_length > MaxPrefixLen) ? MaxPrefixLen : prefix_length;
    mask    = ~(32'hFFFF_FFFF >> len);
    net     = prefix_address & mask;
    shr     = MaxPrefixLen - len;
    src_hit = ((head.source_address & mask) == net);
    dst_hit = ((head.destination_address & mask) == net);
    matched_next          = 1'b0;
    used_destination_next = 1'b0;
    bin_next              = '0;
    if (!head.too_short) begin
      if (src_hit) begin
        matched_next = 1'b1;
        bin_next     = BinBits'(head.source_address >> shr);
      end else if (dst_hit) begin
        matched_next          = 1'b1;
        used_destination_next = 1'b1;
        bin_next              = BinBits'(head.destination_address >> shr);
      end
    end
  end

  // Take the next record whenever the output register is free or draining
  assign pop = head_valid && (!out_valid || out_ready);

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= head_valid;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      matched          <= matched_next;
      used_destination <= used_destination_next;
      bin              <= bin_next;
      too_short        <= head.too_short;
    end
  end

endmodule

@@ rtl/ipv4_prefix_packet_steering.sv @@
// Top level: configuration registers and the parser, queue and matcher.
//
// Usage:
//   Frame bytes enter on the in channel (in_valid / in_ready), one beat per
//   byte in wire order, with last_byte set on the final byte. Each frame gives
//   exactly one result beat on the out channel (out_valid / out_ready) carrying
//   matched, used_destination, bin and too_short.
//   prefix_address and prefix_length are written through cfg_write, cfg_index
//   and cfg_data while no frame is in flight; lengths above 24 act as 24.
// Timing:
//   One byte per cycle is sustained while out_ready stays high, and one frame
//   per cycle for one-byte frames. After a frame's last byte is accepted, its
//   record enters the queue at the accepting edge and moves on into the
//   matcher's output register once that register is free or being drained.
//   A two-entry queue between parser and matcher lets the parser keep taking
//   bytes while a result waits; in_ready drops only when the output register
//   and both queue entries hold finished frames, i.e. three results wait on a
//   stalled out channel. It rises again the cycle after a result is taken.
// Reset:
//   rst clears the parser state, the queue and out_valid, and sets both
//   configuration registers to zero. No clearing pass is needed.
module ipv4_prefix_packet_steering import ipps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              frame_byte,
  input  logic                    last_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    matched,
  output logic                    used_destination,
  output logic [7:0]              bin,
  output logic                    too_short,
  input  logic                    cfg_write,
  input  logic [0:0]              cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  logic [31:0] prefix_address;
  logic [4:0]  prefix_length;
  logic        accept;
  logic        full;
  logic        head_valid;
  logic        pop;
  front_push_t push;
  frame_rec_t  head;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_address <= '0;
      prefix_length  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PREFIX_ADDRESS: prefix_address <= cfg_data[31:0];
        REG_PREFIX_LENGTH:  prefix_length  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  ipps_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .push_out   (push)
  );

  ipps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_in    (push),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  ipps_back u_back (
    .clk              (clk),
    .rst              (rst),
    .prefix_address   (prefix_address),
    .prefix_length    (prefix_length),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .matched          (matched),
    .used_destination (used_destination),
    .bin              (bin),
    .too_short        (too_short)
  );

endmodule

@@ rtl/ipps_checker.sv @@
// Port-level checks for the steering block, bound to its top level.
module ipps_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       matched,
  input logic       used_destination,
  input logic [7:0] bin,
  input logic       too_short
);

  // No result beat right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(matched) &&
      $stable(used_destination) && $stable(bin) && $stable(too_short))
    else $error("stalled result beat changed");

  // Short frames never match
  a_short_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_short |-> !matched && !used_destination && bin == 8'd0)
    else $error("short frame reported a match");

  // Unmatched beats carry a zero bin and no destination flag
  a_nomatch_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !matched |-> !used_destination && bin == 8'd0)
    else $error("unmatched beat carries bin or destination flag");

endmodule

bind ipv4_prefix_packet_steering ipps_checker u_ipps_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .matched          (matched),
  .used_destination (used_destination),
  .bin              (bin),
  .too_short        (too_short)
);

@@ tb/sv/tb.sv @@
// Testbench for the IPv4 prefix packet steering block: byte driver, result checker.
`timescale 1ns / 100ps

module tb;
  import ipps_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       lastb;
  } frame_beat_t;

  typedef struct packed {
    logic       matched;
    logic       used_dst;
    logic [7:0] bin;
    logic       too_short;
  } steer_result_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [7:0]              frame_byte = 8'h00;
  logic                    last_byte = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    matched;
  logic                    used_destination;
  logic [7:0]              bin;
  logic                    too_short;
  logic                    cfg_write = 1'b0;
  logic [0:0]              cfg_index = REG_PREFIX_ADDRESS;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  // Pending bytes and expected frame verdicts
  frame_beat_t   beat_q[$];
  steer_result_t steer_exp_q[$];

  // Mirror of the block: configuration and per-frame parse state
  logic [31:0] cfg_addr = '0;
  logic [4:0]  cfg_len = '0;
  logic [5:0]  frm_offset = '0;
  logic [7:0]  eth_type_hi = '0;
  logic        vlan_flag = 1'b0;
  logic [31:0] src_addr = '0;
  logic [31:0] dst_addr = '0;

  int unsigned err_count = 0;
  int unsigned bytes_queued = 0;
  int unsigned frames_queued = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          no_idle = 1'b0;
  frame_beat_t drv_beat;

  ipv4_prefix_packet_steering u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .frame_byte       (frame_byte),
    .last_byte        (last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .matched          (matched),
    .used_destination (used_destination),
    .bin              (bin),
    .too_short        (too_short),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    err_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic int unsigned clamp_len(input logic [4:0] plen);
    return (plen > MaxPrefixLen) ? MaxPrefixLen : plen;
  endfunction

  function automatic logic [31:0] net_mask(input int unsigned plen);
    if (plen == 0) return '0;
    return ~32'h0 << (32 - plen);
  endfunction

  // Mostly short gaps, a few long ones, none while no_idle is set
  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advance the parse state by one byte; on the last byte queue the verdict
  task automatic steer_byte(input logic [7:0] b, input logic lastb);
    int unsigned   off;
    int unsigned   src0;
    int unsigned   plen;
    int unsigned   shr;
    logic [31:0]   mask;
    logic [31:0]   net_bits;
    steer_result_t res;
    off  = frm_offset;
    src0 = vlan_flag ? SrcStartVlan : SrcStartPlain;
    if (off == EthTypeHiOffset) eth_type_hi = b;
    else if (off == EthTypeLoOffset) vlan_flag = ({eth_type_hi, b} == VlanTpid);
    else if (off >= src0 && off < src0 + 4) src_addr = {src_addr[23:0], b};
    else if (off >= src0 + 4 && off < src0 + 8) dst_addr = {dst_addr[23:0], b};
    if (frm_offset != OffsetMax) frm_offset++;
    if (lastb) begin
      plen     = clamp_len(cfg_len);
      mask     = net_mask(plen);
      net_bits = cfg_addr & mask;
      shr      = 24 - plen;
      res      = '0;
      if (off + 1 < src0 + 8) begin
        res.too_short = 1'b1;
      end else if ((src_addr & mask) == net_bits) begin
        res.matched = 1'b1;
        res.bin     = 8'((src_addr & ~mask) >> shr);
      end else if ((dst_addr & mask) == net_bits) begin
        res.matched  = 1'b1;
        res.used_dst = 1'b1;
        res.bin      = 8'((dst_addr & ~mask) >> shr);
      end
      steer_exp_q.push_back(res);
      frm_offset  = '0;
      eth_type_hi = '0;
      vlan_flag   = 1'b0;
      src_addr    = '0;
      dst_addr    = '0;
    end
  endtask

  // Compare one result beat with the oldest expectation
  task automatic check_result();
    steer_result_t want;
    if (steer_exp_q.size() == 0) begin
      log_mismatch("result beat with no frame outstanding");
      return;
    end
    want = steer_exp_q.pop_front();
    if (matched !== want.matched)
      log_mismatch($sformatf("matched got %b want %b", matched, want.matched));
    if (used_destination !== want.used_dst)
      log_mismatch($sformatf("used_destination got %b want %b",
                             used_destination, want.used_dst));
    if (bin !== want.bin)
      log_mismatch($sformatf("bin got %02h want %02h", bin, want.bin));
    if (too_short !== want.too_short)
      log_mismatch($sformatf("too_short got %b want %b", too_short, want.too_short));
  endtask

  // Byte driver: hold valid until accepted, then pick the next beat or a gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) steer_byte(frame_byte, last_byte);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (beat_q.size() > 0) begin
          drv_beat = beat_q.pop_front();
          in_valid   <= 1'b1;
          frame_byte <= drv_beat.data;
          last_byte  <= drv_beat.lastb;
          gap_left = idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check accepted beats, stall out_ready at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  task automatic write_cfg(input cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_PREFIX_ADDRESS) cfg_addr = val;
    else cfg_len = val[4:0];
  endtask

  task automatic set_prefix(input logic [31:0] addr, input logic [4:0] plen);
    write_cfg(REG_PREFIX_ADDRESS, addr);
    write_cfg(REG_PREFIX_LENGTH, {27'h0, plen});
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Hold off until every byte is taken and every verdict has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (beat_q.size() != 0 || in_valid || steer_exp_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_addr(input bit hit);
    logic [31:0] mask;
    mask = net_mask(clamp_len(cfg_len));
    if (hit) return (cfg_addr & mask) | ($urandom() & ~mask);
    return $urandom();
  endfunction

  // Queue a frame with the given ethertype and addresses at their offsets
  task automatic queue_frame(input int unsigned n, input logic [15:0] etype,
                             input logic [31:0] s, input logic [31:0] d);
    int unsigned base;
    frame_beat_t bt;
    base = (etype == VlanTpid) ? SrcStartVlan : SrcStartPlain;
    for (int unsigned i = 0; i < n; i++) begin
      bt.data = 8'($urandom());
      if (i == EthTypeHiOffset) bt.data = etype[15:8];
      else if (i == EthTypeLoOffset) bt.data = etype[7:0];
      else if (i >= base && i < base + 4) bt.data = s[31 - 8*(i - base) -: 8];
      else if (i >= base + 4 && i < base + 8) bt.data = d[31 - 8*(i - base - 4) -: 8];
      bt.lastb = (i == n - 1);
      beat_q.push_back(bt);
    end
    bytes_queued += n;
    frames_queued++;
  endtask

  task automatic queue_const_frame(input int unsigned n, input logic [7:0] val);
    frame_beat_t bt;
    for (int unsigned i = 0; i < n; i++) begin
      bt.data  = val;
      bt.lastb = (i == n - 1);
      beat_q.push_back(bt);
    end
    bytes_queued += n;
    frames_queued++;
  endtask

  // Mostly well-formed frames with random content, some short, long or noise
  task automatic queue_random_frame();
    int unsigned r;
    int unsigned n;
    int unsigned min_len;
    logic [15:0] etype;
    logic [31:0] s;
    logic [31:0] d;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      queue_frame($urandom_range(1, 40), 16'($urandom()), $urandom(), $urandom());
      return;
    end
    r = $urandom_range(0, 9);
    if (r < 5) etype = VlanTpid;
    else if (r < 7) etype = 16'h0800;
    else if (r == 7) etype = {8'h81, 8'($urandom_range(1, 255))};
    else etype = 16'($urandom());
    if (etype == VlanTpid) min_len = SrcStartVlan + 8;
    else min_len = SrcStartPlain + 8;
    r = $urandom_range(0, 99);
    if (r < 60) n = $urandom_range(min_len, 63);
    else if (r < 75) n = min_len;
    else if (r < 88) n = $urandom_range(1, min_len - 1);
    else n = $urandom_range(64, 90);
    r = $urandom_range(0, 9);
    if (r < 4) begin
      s = pick_addr(1'b1);
      d = pick_addr(1'b0);
    end else if (r < 7) begin
      s = pick_addr(1'b0);
      d = pick_addr(1'b1);
    end else begin
      s = pick_addr(1'b0);
      d = pick_addr(1'b0);
    end
    queue_frame(n, etype, s, d);
  endtask

  initial begin
    logic [31:0] addr;
    logic [4:0]  plen;
    int unsigned r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero prefix, every address matches
    queue_const_frame(1, 8'h00);
    queue_const_frame(34, 8'hFF);
    queue_const_frame(34, 8'h00);
    queue_frame(33, 16'h0800, 32'h1234_5678, 32'h9ABC_DEF0);
    wait_idle();

    // Full-length prefix: source hit, destination hit, miss, tag, short, long, 8101 non-tag
    set_prefix($urandom(), 5'd24);
    queue_frame(34, 16'h0800, pick_addr(1'b1), pick_addr(1'b0));
    queue_frame(34, 16'h0800, cfg_addr ^ 32'h8000_0000, pick_addr(1'b1));
    queue_frame(34, 16'h0800, cfg_addr ^ 32'h8000_0000, cfg_addr ^ 32'h0000_0100);
    queue_frame(38, VlanTpid, pick_addr(1'b1), pick_addr(1'b1));
    queue_frame(37, VlanTpid, pick_addr(1'b1), pick_addr(1'b1));
    queue_frame(80, 16'h0800, pick_addr(1'b0) ^ 32'h0080_0000, pick_addr(1'b1));
    queue_frame(34, 16'h8101, pick_addr(1'b1), pick_addr(1'b0));
    wait_idle();

    // Length above the limit acts as the limit
    set_prefix(32'hFFFF_FFFF, 5'd31);
    queue_frame(34, 16'h0800, pick_addr(1'b1), pick_addr(1'b0));
    queue_frame(40, VlanTpid, pick_addr(1'b0), pick_addr(1'b1));
    wait_idle();

    set_prefix(32'h0000_0000, 5'd0);
    queue_frame(40, VlanTpid, $urandom(), $urandom());
    wait_idle();

    // Random phases, each under its own prefix
    while (bytes_queued < 1350 || frames_queued < 60) begin
      r = $urandom_range(0, 7);
      if (r == 0) addr = '0;
      else if (r == 1) addr = 32'hFFFF_FFFF;
      else addr = $urandom();
      r = $urandom_range(0, 9);
      if (r == 0) plen = 5'd0;
      else if (r == 1) plen = 5'd24;
      else if (r == 2) plen = 5'($urandom_range(25, 31));
      else plen = 5'($urandom_range(1, 23));
      set_prefix(addr, plen);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 8)) queue_random_frame();
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
